// ----- sv/bdgd_pkg.sv -----
// bdgd_pkg: shared types and constants for the button debounce and gesture block
// item structs, function and event codes, register indexes, sequencer states
// no dependencies
`default_nettype none

package bdgd_pkg;

    localparam int NUM_BUTTONS = 5;
    localparam int BTN_W       = 3;
    localparam int STAMP_W     = 32;
    localparam int ENC_W       = 16;
    localparam int TIME_W      = 16;
    localparam int EN_W        = 5;
    localparam int LEVEL_W     = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // item function codes
    localparam logic [1:0] FUNC_EDGE    = 2'd0;
    localparam logic [1:0] FUNC_UPDATE  = 2'd1;
    localparam logic [1:0] FUNC_CAPTURE = 2'd2;

    // event kinds, also the bit position in the enable mask
    localparam logic [2:0] EV_PRESS   = 3'd0;
    localparam logic [2:0] EV_RELEASE = 3'd1;
    localparam logic [2:0] EV_CLICK   = 3'd2;
    localparam logic [2:0] EV_LONG    = 3'd3;
    localparam logic [2:0] EV_SCROLL  = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 2'd2;

    localparam logic [TIME_W-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [TIME_W-1:0] LONG_RST     = 16'd1000;
    localparam logic [EN_W-1:0]   ENABLE_RST   = 5'd31;

    typedef struct packed {
        logic [1:0]         func;
        logic [BTN_W-1:0]   button_index;
        logic               pin_level;
        logic [LEVEL_W-1:0] button_levels;
        logic [STAMP_W-1:0] now_ms;
        logic [ENC_W-1:0]   encoder_count;
    } req_t;

    typedef struct packed {
        logic [2:0]              event_kind;
        logic [BTN_W-1:0]        event_button;
        logic signed [ENC_W-1:0] scroll_delta;
        logic                    last;
    } evt_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_EVAL,
        ST_CLICK,
        ST_SCROLL,
        ST_FLUSH
    } state_t;

endpackage

`default_nettype wire

// ----- sv/button_debounce_gesture_detector.sv -----
// an edge item steps through the diff, eval and optional click states for its one button, an update item
// walks the buttons the same way through one shared 32-bit tick subtractor, then adds a scroll step;
// a capture item only latches the scroll stamp; a new item is taken only once the sequencer is idle,
// and a stalled result output holds the sequencer
// reset: asynchronous, active low; stamps, flags and encoder copy clear to zero,
// registers return to debounce 50, long press 1000, all events enabled
// depends on bdgd_pkg
`default_nettype none

module button_debounce_gesture_detector (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             req_valid,
    output logic                                  req_stall,
    input  wire bdgd_pkg::req_t                   req,
    output logic                                  evt_valid,
    input  wire logic                             evt_stall,
    output bdgd_pkg::evt_t                        evt,
    input  wire logic                             cfg_we,
    input  wire logic [bdgd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bdgd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import bdgd_pkg::*;

    state_t state_reg, state_next;

    logic [TIME_W-1:0]  debounce_reg;
    logic [TIME_W-1:0]  long_reg;
    logic [EN_W-1:0]    enable_reg;

    logic [STAMP_W-1:0] press_stamp_reg   [NUM_BUTTONS];
    logic [STAMP_W-1:0] release_stamp_reg [NUM_BUTTONS];
    logic               held_reg          [NUM_BUTTONS];
    logic               long_fired_reg    [NUM_BUTTONS];
    logic [STAMP_W-1:0] scroll_stamp_reg;
    logic [ENC_W-1:0]   last_enc_reg;

    // latched item
    logic [1:0]         func_reg;
    logic               level_reg;
    logic [LEVEL_W-1:0] levels_reg;
    logic [STAMP_W-1:0] now_reg;
    logic [ENC_W-1:0]   count_reg;

    logic [BTN_W-1:0]   cur_reg;
    logic [STAMP_W-1:0] diff_reg;

    logic               pend_valid_reg;
    evt_t               pend_reg;
    logic               evt_valid_reg;
    evt_t               evt_reg;

    // shared tick subtractor
    logic [STAMP_W-1:0] sub_b;
    logic [STAMP_W-1:0] sub_y;

    logic               load;
    logic               cur_inc;
    logic               emit;
    logic [2:0]         emit_kind;
    logic               do_press;
    logic               do_release;
    logic               do_long;
    logic               do_scroll;
    logic               move;
    logic               move_last;
    logic               go;
    logic               out_free;
    logic               is_edge;
    logic               last_btn;
    logic               lv;
    logic               settled;
    logic               want_press;
    logic               want_release;
    logic               want_long;
    logic               press_ok;
    logic               release_ok;
    logic               click;
    logic               long_shown;
    logic [ENC_W-1:0]   enc_delta;

    assign sub_b = (state_reg == ST_DIFF) ? press_stamp_reg[cur_reg]
                                          : release_stamp_reg[cur_reg];
    assign sub_y = now_reg - sub_b;

    assign out_free  = !evt_valid_reg || !evt_stall;
    assign go        = !pend_valid_reg || out_free;
    assign is_edge   = (func_reg == FUNC_EDGE);
    assign last_btn  = is_edge || (cur_reg == BTN_W'(NUM_BUTTONS - 1));
    assign lv        = levels_reg[cur_reg];
    assign enc_delta = count_reg - last_enc_reg;

    // diff_reg holds now - press stamp, sub_y gives now - release stamp in the eval step
    assign settled = (diff_reg > STAMP_W'(debounce_reg)) && (sub_y > STAMP_W'(debounce_reg));

    always_comb
    begin
        if (is_edge)
        begin
            want_press   = level_reg;
            want_release = !level_reg;
            want_long    = 1'b0;
        end
        else
        begin
            want_press   = !held_reg[cur_reg] && lv;
            want_release = held_reg[cur_reg] && !lv;
            want_long    = held_reg[cur_reg] && lv && !long_fired_reg[cur_reg]
                           && (diff_reg > STAMP_W'(long_reg));
        end
    end

    assign press_ok   = want_press && settled;
    assign release_ok = want_release && settled;
    assign click      = release_ok && (diff_reg < STAMP_W'(long_reg));
    assign long_shown = !(scroll_stamp_reg > press_stamp_reg[cur_reg]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        load       = 1'b0;
        cur_inc    = 1'b0;
        emit       = 1'b0;
        emit_kind  = EV_PRESS;
        do_press   = 1'b0;
        do_release = 1'b0;
        do_long    = 1'b0;
        do_scroll  = 1'b0;
        move       = 1'b0;
        move_last  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    load = 1'b1;
                    priority if (req.func == FUNC_UPDATE)
                        state_next = ST_DIFF;
                    else if (req.func == FUNC_EDGE
                             && req.button_index < BTN_W'(NUM_BUTTONS))
                        state_next = ST_DIFF;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_DIFF:
                state_next = ST_EVAL;
            ST_EVAL:
            begin
                if (go)
                begin
                    do_press   = press_ok;
                    do_release = release_ok;
                    do_long    = want_long;
                    priority if (press_ok)
                        emit_kind = EV_PRESS;
                    else if (release_ok)
                        emit_kind = EV_RELEASE;
                    else
                        emit_kind = EV_LONG;
                    emit = (press_ok || release_ok || (want_long && long_shown))
                           && enable_reg[emit_kind];
                    priority if (click)
                        state_next = ST_CLICK;
                    else if (!last_btn)
                        state_next = ST_DIFF;
                    else if (is_edge)
                        state_next = ST_FLUSH;
                    else
                        state_next = ST_SCROLL;
                    cur_inc = !click && !last_btn;
                end
            end
            ST_CLICK:
            begin
                if (go)
                begin
                    emit_kind = EV_CLICK;
                    emit      = enable_reg[EV_CLICK];
                    priority if (!last_btn)
                        state_next = ST_DIFF;
                    else if (is_edge)
                        state_next = ST_FLUSH;
                    else
                        state_next = ST_SCROLL;
                    cur_inc = !last_btn;
                end
            end
            ST_SCROLL:
            begin
                if (go)
                begin
                    emit_kind  = EV_SCROLL;
                    do_scroll  = enable_reg[EV_SCROLL] && (last_enc_reg != count_reg);
                    emit       = do_scroll;
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                    state_next = ST_IDLE;
                else if (out_free)
                begin
                    move       = 1'b1;
                    move_last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
        // a new result pushes the waiting one out, not yet the final one
        if (emit && pend_valid_reg)
            move = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg     <= DEBOUNCE_RST;
            long_reg         <= LONG_RST;
            enable_reg       <= ENABLE_RST;
            scroll_stamp_reg <= '0;
            last_enc_reg     <= '0;
            cur_reg          <= '0;
            pend_valid_reg   <= 1'b0;
            evt_valid_reg    <= 1'b0;
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                press_stamp_reg[i]   <= '0;
                release_stamp_reg[i] <= '0;
                held_reg[i]          <= 1'b0;
                long_fired_reg[i]    <= 1'b0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_DEBOUNCE: debounce_reg <= cfg_data[TIME_W-1:0];
                    CFG_LONG:     long_reg     <= cfg_data[TIME_W-1:0];
                    CFG_ENABLE:   enable_reg   <= cfg_data[EN_W-1:0];
                    default:      ;
                endcase
            end

            if (load)
            begin
                cur_reg <= (req.func == FUNC_EDGE) ? req.button_index : '0;
                if (req.func == FUNC_CAPTURE)
                    scroll_stamp_reg <= req.now_ms;
            end
            else if (cur_inc)
                cur_reg <= cur_reg + BTN_W'(1);

            if (do_press)
            begin
                press_stamp_reg[cur_reg] <= now_reg;
                held_reg[cur_reg]        <= 1'b1;
                long_fired_reg[cur_reg]  <= 1'b0;
            end
            if (do_release)
            begin
                release_stamp_reg[cur_reg] <= now_reg;
                held_reg[cur_reg]          <= 1'b0;
                long_fired_reg[cur_reg]    <= 1'b0;
            end
            if (do_long)
                long_fired_reg[cur_reg] <= 1'b1;
            if (do_scroll)
                last_enc_reg <= count_reg;

            if (emit)
                pend_valid_reg <= 1'b1;
            else if (move)
                pend_valid_reg <= 1'b0;

            if (move)
                evt_valid_reg <= 1'b1;
            else if (!evt_stall)
                evt_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            func_reg   <= req.func;
            level_reg  <= req.pin_level;
            levels_reg <= req.button_levels;
            now_reg    <= req.now_ms;
            count_reg  <= req.encoder_count;
        end
        if (state_reg == ST_DIFF)
            diff_reg <= sub_y;
        if (emit)
        begin
            pend_reg.event_kind   <= emit_kind;
            pend_reg.event_button <= (emit_kind == EV_SCROLL) ? '0 : cur_reg;
            pend_reg.scroll_delta <= (emit_kind == EV_SCROLL) ? $signed(enc_delta) : '0;
            pend_reg.last         <= 1'b0;
        end
        if (move)
        begin
            evt_reg.event_kind   <= pend_reg.event_kind;
            evt_reg.event_button <= pend_reg.event_button;
            evt_reg.scroll_delta <= pend_reg.scroll_delta;
            evt_reg.last         <= move_last;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign evt_valid = evt_valid_reg;
    assign evt       = evt_reg;

endmodule

`default_nettype wire

// ----- tb/button_debounce_gesture_detector_tb.sv -----
// button_debounce_gesture_detector_tb: self-checking bench for the button and encoder qualifier
// drives edge, update and capture items, predicts every gesture event and checks it in order
// depends on bdgd_pkg and button_debounce_gesture_detector
`timescale 1ns / 1ps

module button_debounce_gesture_detector_tb;

    import bdgd_pkg::*;

    localparam logic [1:0] FUNC_UNUSED  = 2'd3;
    localparam int         LIMIT_CYCLES = 400000;
    localparam int         SETTLE_CYCLES = 24;

    logic                  clk;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_stall;
    req_t                  req;
    logic                  evt_valid;
    logic                  evt_stall;
    evt_t                  evt;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // shadow of the block state and registers
    logic [STAMP_W-1:0] press_at   [NUM_BUTTONS];
    logic [STAMP_W-1:0] release_at [NUM_BUTTONS];
    logic               held       [NUM_BUTTONS];
    logic               long_done  [NUM_BUTTONS];
    logic [STAMP_W-1:0] scroll_at;
    logic [ENC_W-1:0]   enc_seen;
    logic [TIME_W-1:0]  debounce_q;
    logic [TIME_W-1:0]  long_q;
    logic [EN_W-1:0]    enable_q;

    evt_t step_evts[$];
    evt_t events_due[$];

    int                 error_count;
    int                 cycle_count;
    int                 hold_len;
    logic               idle_on;
    logic [STAMP_W-1:0] cur_ms;
    logic [ENC_W-1:0]   enc_now;
    logic [LEVEL_W-1:0] held_pattern;

    button_debounce_gesture_detector u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("button_debounce_gesture_detector regression: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------- gesture prediction

    function automatic void add_event(input logic [2:0] kind, input int b,
                                      input logic [ENC_W-1:0] delta);
        evt_t e;
        if (enable_q[kind])
        begin
            e.event_kind   = kind;
            e.event_button = b[BTN_W-1:0];
            e.scroll_delta = delta;
            e.last         = 1'b0;
            step_evts.push_back(e);
        end
    endfunction

    function automatic logic settled(input int b, input logic [STAMP_W-1:0] now);
        return ((now - press_at[b]) > {16'd0, debounce_q}) &&
               ((now - release_at[b]) > {16'd0, debounce_q});
    endfunction

    function automatic void try_press(input int b, input logic [STAMP_W-1:0] now);
        if (settled(b, now))
        begin
            press_at[b]  = now;
            held[b]      = 1'b1;
            long_done[b] = 1'b0;
            add_event(EV_PRESS, b, '0);
        end
    endfunction

    function automatic void try_release(input int b, input logic [STAMP_W-1:0] now);
        if (settled(b, now))
        begin
            release_at[b] = now;
            held[b]       = 1'b0;
            long_done[b]  = 1'b0;
            add_event(EV_RELEASE, b, '0);
            if ((now - press_at[b]) < {16'd0, long_q})
                add_event(EV_CLICK, b, '0);
        end
    endfunction

    function automatic void qualify_item(input req_t item);
        evt_t e;
        int   i;
        logic lv;
        step_evts.delete();
        case (item.func)
            FUNC_EDGE:
            begin
                if (item.button_index < NUM_BUTTONS)
                begin
                    if (item.pin_level)
                        try_press(int'(item.button_index), item.now_ms);
                    else
                        try_release(int'(item.button_index), item.now_ms);
                end
            end
            FUNC_UPDATE:
            begin
                for (i = 0; i < NUM_BUTTONS; i++)
                begin
                    lv = (i < LEVEL_W) ? item.button_levels[i] : 1'b0;
                    if (held[i])
                    begin
                        if (!lv)
                            try_release(i, item.now_ms);
                        else if (!long_done[i] &&
                                 (item.now_ms - press_at[i]) > {16'd0, long_q})
                        begin
                            long_done[i] = 1'b1;
                            // a scroll stamped after the press swallows the long press
                            if (!(scroll_at > press_at[i]))
                                add_event(EV_LONG, i, '0);
                        end
                    end
                    else if (lv)
                        try_press(i, item.now_ms);
                end
                if (enable_q[EV_SCROLL] && enc_seen != item.encoder_count)
                begin
                    add_event(EV_SCROLL, 0, ENC_W'(item.encoder_count - enc_seen));
                    enc_seen = item.encoder_count;
                end
            end
            FUNC_CAPTURE:
                scroll_at = item.now_ms;
            default:
            begin
            end
        endcase
        if (step_evts.size() > 0)
        begin
            e = step_evts.pop_back();
            e.last = 1'b1;
            step_evts.push_back(e);
        end
        while (step_evts.size() > 0)
            events_due.push_back(step_evts.pop_front());
    endfunction

    // ---------------------------------------------------------------- item builders

    function automatic req_t edge_item(input int b, input logic lvl,
                                       input logic [STAMP_W-1:0] now);
        req_t item;
        item.func          = FUNC_EDGE;
        item.button_index  = b[BTN_W-1:0];
        item.pin_level     = lvl;
        item.button_levels = LEVEL_W'($urandom_range(0, 31));
        item.now_ms        = now;
        item.encoder_count = ENC_W'($urandom_range(0, 65535));
        return item;
    endfunction

    function automatic req_t update_item(input logic [LEVEL_W-1:0] levels,
                                         input logic [STAMP_W-1:0] now,
                                         input logic [ENC_W-1:0] count);
        req_t item;
        item.func          = FUNC_UPDATE;
        item.button_index  = BTN_W'($urandom_range(0, 7));
        item.pin_level     = 1'($urandom_range(0, 1));
        item.button_levels = levels;
        item.now_ms        = now;
        item.encoder_count = count;
        return item;
    endfunction

    function automatic req_t capture_item(input logic [STAMP_W-1:0] now);
        req_t item;
        item.func          = FUNC_CAPTURE;
        item.button_index  = BTN_W'($urandom_range(0, 7));
        item.pin_level     = 1'($urandom_range(0, 1));
        item.button_levels = LEVEL_W'($urandom_range(0, 31));
        item.now_ms        = now;
        item.encoder_count = ENC_W'($urandom_range(0, 65535));
        return item;
    endfunction

    // tick advance scaled to the current debounce and long press times
    function automatic logic [STAMP_W-1:0] tick_step();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 2)
            return $urandom_range(0, int'(debounce_q));
        else if (pick < 6)
            return int'(debounce_q) + $urandom_range(1, int'(long_q) + 1);
        else if (pick < 9)
            return int'(long_q) + $urandom_range(1, int'(long_q) + 50);
        else
            return $urandom();
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic send_item(input req_t item);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 5);
        repeat (gap)
        begin
            @(negedge clk);
            req_valid = 1'b0;
        end
        @(negedge clk);
        req_valid = 1'b1;
        req       = item;
        do
            @(posedge clk);
        while (req_stall);
        qualify_item(item);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        req_valid = 1'b0;
        while (events_due.size() != 0)
            @(posedge clk);
        // items that give no event may still be in the pipe
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        @(negedge clk);
        cfg_we = 1'b0;
        case (index)
            CFG_DEBOUNCE: debounce_q = data;
            CFG_LONG:     long_q     = data;
            CFG_ENABLE:   enable_q   = data[EN_W-1:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic set_config(input logic [TIME_W-1:0] deb, input logic [TIME_W-1:0] lng,
                              input logic [EN_W-1:0] en);
        logic [CFG_DATA_W-EN_W-1:0] pad;
        pad = (CFG_DATA_W - EN_W)'($urandom_range(0, 2047));
        wait_idle();
        write_reg(CFG_DEBOUNCE, deb);
        write_reg(CFG_LONG, lng);
        write_reg(CFG_ENABLE, {pad, en});
    endtask

    // receiver side: random stall bursts, or one long hold when asked
    initial
    begin
        evt_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_len > 0)
            begin
                evt_stall = 1'b1;
                repeat (hold_len) @(negedge clk);
                hold_len  = 0;
                evt_stall = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                evt_stall = 1'b1;
                repeat ($urandom_range(1, 5)) @(negedge clk);
                evt_stall = 1'b0;
            end
            else
                evt_stall = 1'b0;
        end
    end

    // ---------------------------------------------------------------- event checker

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin : watch_events
        evt_t due;
        if (rst_n && evt_valid && !evt_stall)
        begin
            if (events_due.size() == 0)
            begin
                $error("event with none due: kind %0d button %0d", evt.event_kind,
                       evt.event_button);
                error_count++;
            end
            else
            begin
                due = events_due.pop_front();
                check_field("event_kind", due.event_kind, evt.event_kind);
                check_field("event_button", due.event_button, evt.event_button);
                check_field("scroll_delta", $signed(due.scroll_delta), $signed(evt.scroll_delta));
                check_field("last", due.last, evt.last);
            end
        end
    end

    // ---------------------------------------------------------------- tests

    task automatic test_default_gestures();
        req_t item;
        send_item(edge_item(0, 1'b1, 32'd0));          // no tick since reset stamps
        send_item(edge_item(0, 1'b1, 32'd51));
        send_item(edge_item(0, 1'b0, 32'd90));         // bounce, rejected
        send_item(edge_item(0, 1'b0, 32'd200));        // release and click
        item = capture_item(32'd300);
        item.func = FUNC_UNUSED;
        send_item(item);
        send_item(edge_item(7, 1'b1, 32'd500));        // buttons past the end are ignored
        send_item(edge_item(5, 1'b0, 32'd510));
        send_item(update_item(5'h1F, 32'd600, 16'h8000));
        send_item(update_item(5'h1F, 32'd1700, 16'h8000));
        send_item(update_item(5'h00, 32'd1800, 16'hFFFF));
        send_item(capture_item(32'hFFFF_FFFF));
        send_item(edge_item(2, 1'b1, 32'hFFFF_FFF0));
        // tick wraps; scroll stamp is above the press stamp so the long press is dropped
        send_item(update_item(5'h04, 32'h0000_0500, 16'hFFFF));
        send_item(update_item(5'h1F, 32'h0000_0600, 16'h0000));
        send_item(update_item(5'h00, 32'h0000_0700, 16'h0001));
    endtask

    task automatic test_register_extremes();
        set_config(16'd0, 16'd0, 5'h1F);
        send_item(capture_item(32'd0));
        send_item(edge_item(3, 1'b1, 32'h0000_1000));
        send_item(update_item(5'h08, 32'h0000_1001, 16'h0001));   // long press after one tick
        send_item(edge_item(3, 1'b0, 32'h0000_1001));             // no click with a zero long press time
        send_item(edge_item(3, 1'b1, 32'h0000_1001));             // no tick since the release
        set_config(16'd0, 16'd0, 5'h00);
        send_item(update_item(5'h1F, 32'h0000_2000, 16'h1234));   // state moves, nothing reported
        set_config(16'hFFFF, 16'hFFFF, 5'h1F);
        send_item(update_item(5'h00, 32'h0001_1FFF, 16'h1234));
        send_item(update_item(5'h00, 32'h0001_2000, 16'h1234));
    endtask

    task automatic test_scroll_suppresses_long();
        logic [STAMP_W-1:0] t0;
        t0 = 32'h0003_0000;
        set_config(16'd10, 16'd100, 5'h1F);
        send_item(edge_item(1, 1'b1, t0));
        send_item(capture_item(t0 + 32'd5));
        send_item(update_item(5'h02, t0 + 32'd200, 16'h1234));
        send_item(edge_item(1, 1'b0, t0 + 32'd300));
        send_item(edge_item(1, 1'b1, t0 + 32'd400));
        send_item(update_item(5'h02, t0 + 32'd600, 16'h1234));
        send_item(edge_item(1, 1'b0, t0 + 32'd650));
        send_item(edge_item(1, 1'b1, t0 + 32'd700));
        send_item(edge_item(1, 1'b0, t0 + 32'd750));
    endtask

    task automatic test_backpressure();
        int k;
        set_config(16'd0, 16'd1000, 5'h1F);
        cur_ms = 32'h0004_0000;
        hold_len = 400;
        // every other item releases all buttons with clicks plus a scroll
        for (k = 0; k < 40; k++)
        begin
            cur_ms = cur_ms + 32'd10;
            send_item(update_item((k % 2 == 1) ? 5'h00 : 5'h1F, cur_ms,
                                  ENC_W'($urandom_range(0, 65535))));
        end
    endtask

    task automatic run_random(input int count);
        int                 sent;
        int                 pick;
        int                 b;
        int                 n;
        int                 k;
        logic [LEVEL_W-1:0] levels;
        req_t               item;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 7)
            begin
                b = ($urandom_range(0, 11) == 0) ? $urandom_range(NUM_BUTTONS, 7)
                                                 : $urandom_range(0, NUM_BUTTONS - 1);
                if (b >= NUM_BUTTONS)
                begin
                    cur_ms = cur_ms + tick_step();
                    send_item(edge_item(b, 1'($urandom_range(0, 1)), cur_ms));
                    sent++;
                end
                else
                begin
                    held_pattern[b] = ~held_pattern[b];
                    n = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1;
                    // contact bounce: alternate levels, ending on the new level
                    for (k = n - 1; k >= 0; k--)
                    begin
                        if (k == n - 1)
                            cur_ms = cur_ms + tick_step();
                        else
                            cur_ms = cur_ms + $urandom_range(0, int'(debounce_q) + 2);
                        send_item(edge_item(b, held_pattern[b] ^ (k % 2 == 1), cur_ms));
                    end
                    sent += n;
                end
            end
            else if (pick < 16)
            begin
                levels = ($urandom_range(0, 7) == 0) ? LEVEL_W'($urandom_range(0, 31))
                                                     : held_pattern;
                if ($urandom_range(0, 7) == 0)
                    enc_now = ENC_W'($urandom_range(0, 65535));
                else if ($urandom_range(0, 2) != 0)
                    enc_now = ENC_W'(enc_now + $urandom_range(0, 64) - 32);
                cur_ms = cur_ms + tick_step();
                send_item(update_item(levels, cur_ms, enc_now));
                sent++;
            end
            else if (pick < 19)
            begin
                cur_ms = cur_ms + $urandom_range(0, int'(long_q));
                send_item(capture_item(cur_ms));
                sent++;
            end
            else
            begin
                item = capture_item(cur_ms);
                item.func = FUNC_UNUSED;
                send_item(item);
                sent++;
            end
        end
    endtask

    task automatic test_random_traffic();
        set_config(TIME_W'($urandom_range(0, 20)), TIME_W'($urandom_range(30, 300)), 5'h1F);
        cur_ms = 32'h0005_0000;
        run_random(75);
        set_config(TIME_W'($urandom_range(0, 30)), TIME_W'($urandom_range(1, 2000)),
                   EN_W'($urandom_range(0, 31)));
        cur_ms = 32'hFFFF_F000;
        run_random(75);
        set_config(DEBOUNCE_RST, LONG_RST, EN_W'($urandom_range(1, 31)));
        run_random(75);
        set_config(TIME_W'($urandom_range(0, 20)), TIME_W'($urandom_range(30, 300)), 5'h1F);
        idle_on = 1'b0;
        run_random(73);
    endtask

    // ---------------------------------------------------------------- sequence

    initial
    begin
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        error_count  = 0;
        cycle_count  = 0;
        hold_len     = 0;
        idle_on      = 1'b1;
        cur_ms       = '0;
        enc_now      = '0;
        held_pattern = '0;
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            press_at[i]   = '0;
            release_at[i] = '0;
            held[i]       = 1'b0;
            long_done[i]  = 1'b0;
        end
        scroll_at  = '0;
        enc_seen   = '0;
        debounce_q = DEBOUNCE_RST;
        long_q     = LONG_RST;
        enable_q   = ENABLE_RST;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_default_gestures();
        test_register_extremes();
        test_scroll_suppresses_long();
        test_backpressure();
        test_random_traffic();

        wait_idle();
        if (error_count == 0)
            $display("button_debounce_gesture_detector regression: pass");
        else
            $display("button_debounce_gesture_detector regression: fail");
        $finish;
    end

endmodule
